// ----- design/small_rsa_crypt_unit_assert.svh -----
// Assertion macros for the RSA unit
`ifndef SMALL_RSA_CRYPT_UNIT_ASSERT_SVH
`define SMALL_RSA_CRYPT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SRSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/srsa_pkg.sv -----
package srsa_pkg;

  localparam int DW = 30;
  localparam int PW = 15;
  localparam int CW = 5;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_PRIMES = 2'd1,
    STAT_NO_EXP     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PRIME_P = 2'd0,
    REG_PRIME_Q = 2'd1,
    REG_DEC_EXP = 2'd2,
    REG_DEC_MOD = 2'd3
  } reg_idx_t;

  localparam logic ACT_ENC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KINIT,
    ST_PTEST,
    ST_PDIV,
    ST_ECHK,
    ST_GCD,
    ST_GW,
    ST_DQ,
    ST_DT,
    ST_DW,
    ST_PMODW,
    ST_PLOOP,
    ST_PMR,
    ST_PSW
  } state_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] m;
  } mul_req_t;

endpackage

// ----- design/srsa_div.sv -----
module srsa_div (
  input  logic             clk,
  input  logic             rst,
  input  srsa_pkg::div_req_t req,
  output logic             done,
  output logic [srsa_pkg::DW-1:0] quo,
  output logic [srsa_pkg::DW-1:0] rem
);
  import srsa_pkg::*;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvs;
  logic [DW:0]   shifted;
  logic          ge;
  logic [DW:0]   diff;

  assign shifted = {rem, quo[DW-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= CW'(DW - 1);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[DW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- design/srsa_mulmod.sv -----
module srsa_mulmod (
  input  logic             clk,
  input  logic             rst,
  input  srsa_pkg::mul_req_t req,
  output logic             done,
  output logic [srsa_pkg::DW-1:0] prod
);
  import srsa_pkg::*;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] a;
  logic [DW-1:0] b;
  logic [DW-1:0] m;
  logic [DW:0]   s1;
  logic [DW:0]   s2;
  logic [DW:0]   s1_red;
  logic [DW:0]   s2_red;

  // operands stay below m, so one conditional subtract reduces each sum
  assign s1     = {1'b0, prod} + {1'b0, a};
  assign s2     = {1'b0, a} + {1'b0, a};
  assign s1_red = (s1 >= {1'b0, m}) ? s1 - {1'b0, m} : s1;
  assign s2_red = (s2 >= {1'b0, m}) ? s2 - {1'b0, m} : s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= '0;
      a    <= req.a;
      b    <= req.b;
      m    <= req.m;
      cnt  <= CW'(DW - 1);
    end else if (busy) begin
      if (b[0]) begin
        prod <= s1_red[DW-1:0];
      end
      a   <= s2_red[DW-1:0];
      b   <= {1'b0, b[DW-1:1]};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- design/small_rsa_crypt_unit.sv -----
// An operation reduces the base with the divider, then squares once per exponent bit and
// multiplies once more for each set bit before it posts the result.
// A bad key on encrypt, or a decrypt modulus below 2, answers with zero straight from idle.
// Throughput: one item at a time; the shared divider and modular multiplier set it.
// Key derivation runs after reset and after each prime write; busy stays high meanwhile.
// Reset is synchronous; the receiver cannot stall, a result is shown one cycle.
module small_rsa_crypt_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [29:0] value_in,
  output logic        done,
  output logic [29:0] value_out,
  output logic [1:0]  status,
  output logic [29:0] pub_exponent,
  output logic [29:0] priv_exponent,
  output logic [29:0] key_modulus,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [29:0] wr_data
);
  import srsa_pkg::*;

  state_t        state, state_next;
  logic [PW-1:0] prime_p, prime_q;
  logic [DW-1:0] dec_exponent, dec_modulus;
  status_t       key_status, key_status_next;
  logic [DW-1:0] key_e, key_e_next, key_d, key_d_next, key_n, key_n_next;
  logic          chk_sel, chk_sel_next;
  logic [15:0]   f, f_next;
  logic [DW-1:0] phi, phi_next, ga, ga_next, gb, gb_next;
  logic [DW-1:0] qpe, qpe_next, remv, remv_next, tacc, tacc_next, qacc, qacc_next;
  logic          act, act_next;
  logic [DW-1:0] m, m_next, ex, ex_next, base, base_next, acc, acc_next;
  logic          done_next;
  logic [DW-1:0] value_out_next;
  logic [PW-1:0] cand;
  logic [31:0]   f_sq;
  div_req_t      div_req;
  mul_req_t      mul_req;
  logic          div_done, mul_done;
  logic [DW-1:0] div_quo, div_rem, mul_prod;

  srsa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  srsa_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign cand = chk_sel ? prime_q : prime_p;
  assign f_sq = 32'(f) * 32'(f);

  assign busy          = (state != ST_IDLE);
  assign status        = key_status;
  assign pub_exponent  = key_e;
  assign priv_exponent = key_d;
  assign key_modulus   = key_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p      <= PW'(61);
      prime_q      <= PW'(53);
      dec_exponent <= '0;
      dec_modulus  <= DW'(2);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PRIME_P: prime_p      <= wr_data[PW-1:0];
        REG_PRIME_Q: prime_q      <= wr_data[PW-1:0];
        REG_DEC_EXP: dec_exponent <= wr_data;
        REG_DEC_MOD: dec_modulus  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KINIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key_status <= key_status_next;
    key_e      <= key_e_next;
    key_d      <= key_d_next;
    key_n      <= key_n_next;
    chk_sel    <= chk_sel_next;
    f          <= f_next;
    phi        <= phi_next;
    ga         <= ga_next;
    gb         <= gb_next;
    qpe        <= qpe_next;
    remv       <= remv_next;
    tacc       <= tacc_next;
    qacc       <= qacc_next;
    act        <= act_next;
    m          <= m_next;
    ex         <= ex_next;
    base       <= base_next;
    acc        <= acc_next;
    value_out  <= value_out_next;
  end

  always_comb begin
    state_next      = state;
    done_next       = 1'b0;
    key_status_next = key_status;
    key_e_next      = key_e;
    key_d_next      = key_d;
    key_n_next      = key_n;
    chk_sel_next    = chk_sel;
    f_next          = f;
    phi_next        = phi;
    ga_next         = ga;
    gb_next         = gb;
    qpe_next        = qpe;
    remv_next       = remv;
    tacc_next       = tacc;
    qacc_next       = qacc;
    act_next        = act;
    m_next          = m;
    ex_next         = ex;
    base_next       = base;
    acc_next        = acc;
    value_out_next  = value_out;
    div_req         = '0;
    mul_req         = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          act_next = action;
          if (action == ACT_ENC) begin
            if (key_status != STAT_OK) begin
              value_out_next = '0;
              done_next      = 1'b1;
            end else begin
              m_next           = key_n;
              ex_next          = key_e;
              div_req.start    = 1'b1;
              div_req.dividend = {{(DW-8){1'b0}}, value_in[7:0]};
              div_req.divisor  = key_n;
              state_next       = ST_PMODW;
            end
          end else begin
            if (dec_modulus < DW'(2)) begin
              value_out_next = '0;
              done_next      = 1'b1;
            end else begin
              m_next           = dec_modulus;
              ex_next          = dec_exponent;
              div_req.start    = 1'b1;
              div_req.dividend = value_in;
              div_req.divisor  = dec_modulus;
              state_next       = ST_PMODW;
            end
          end
        end
      end
      ST_KINIT: begin
        key_e_next   = '0;
        key_d_next   = '0;
        key_n_next   = '0;
        chk_sel_next = 1'b0;
        f_next       = 16'd2;
        state_next   = ST_PTEST;
      end
      // trial division of p, then q
      ST_PTEST: begin
        if (cand < PW'(2)) begin
          key_status_next = STAT_BAD_PRIMES;
          state_next      = ST_IDLE;
        end else if (f_sq > {17'd0, cand}) begin
          if (!chk_sel) begin
            chk_sel_next = 1'b1;
            f_next       = 16'd2;
          end else if (prime_p == prime_q) begin
            key_status_next = STAT_BAD_PRIMES;
            state_next      = ST_IDLE;
          end else begin
            key_n_next = DW'(prime_p) * DW'(prime_q);
            phi_next   = (DW'(prime_p) - DW'(1)) * (DW'(prime_q) - DW'(1));
            key_e_next = DW'(2);
            state_next = ST_ECHK;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DW'(cand);
          div_req.divisor  = DW'(f);
          state_next       = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            key_status_next = STAT_BAD_PRIMES;
            key_n_next      = '0;
            state_next      = ST_IDLE;
          end else begin
            f_next     = f + 1'b1;
            state_next = ST_PTEST;
          end
        end
      end
      ST_ECHK: begin
        if (key_e >= phi) begin
          key_status_next = STAT_NO_EXP;
          key_e_next      = '0;
          state_next      = ST_IDLE;
        end else begin
          ga_next    = key_e;
          gb_next    = phi;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gb == '0) begin
          if (ga == DW'(1)) begin
            div_req.start    = 1'b1;
            div_req.dividend = phi;
            div_req.divisor  = key_e;
            state_next       = ST_DQ;
          end else begin
            key_e_next = key_e + 1'b1;
            state_next = ST_ECHK;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ga;
          div_req.divisor  = gb;
          state_next       = ST_GW;
        end
      end
      ST_GW: begin
        if (div_done) begin
          ga_next    = gb;
          gb_next    = div_rem;
          state_next = ST_GCD;
        end
      end
      ST_DQ: begin
        if (div_done) begin
          qpe_next   = div_quo;
          remv_next  = div_rem;
          tacc_next  = div_rem + 1'b1;
          qacc_next  = div_quo;
          state_next = ST_DT;
        end
      end
      // tacc = j*rem + 1, qacc = j*(phi/e), stepped with j
      ST_DT: begin
        div_req.start    = 1'b1;
        div_req.dividend = tacc;
        div_req.divisor  = key_e;
        state_next       = ST_DW;
      end
      ST_DW: begin
        if (div_done) begin
          if (div_rem == '0) begin
            key_d_next      = qacc + div_quo;
            key_status_next = STAT_OK;
            state_next      = ST_IDLE;
          end else begin
            tacc_next  = tacc + remv;
            qacc_next  = qacc + qpe;
            state_next = ST_DT;
          end
        end
      end
      ST_PMODW: begin
        if (div_done) begin
          base_next  = div_rem;
          acc_next   = DW'(1);
          state_next = ST_PLOOP;
        end
      end
      ST_PLOOP: begin
        if (ex == '0) begin
          value_out_next = (act == ACT_DEC) ? {{(DW-8){1'b0}}, acc[7:0]} : acc;
          done_next      = 1'b1;
          state_next     = ST_IDLE;
        end else if (ex[0]) begin
          mul_req.start = 1'b1;
          mul_req.a     = acc;
          mul_req.b     = base;
          mul_req.m     = m;
          state_next    = ST_PMR;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = base;
          mul_req.b     = base;
          mul_req.m     = m;
          state_next    = ST_PSW;
        end
      end
      ST_PMR: begin
        if (mul_done) begin
          acc_next      = mul_prod;
          mul_req.start = 1'b1;
          mul_req.a     = base;
          mul_req.b     = base;
          mul_req.m     = m;
          state_next    = ST_PSW;
        end
      end
      ST_PSW: begin
        if (mul_done) begin
          base_next  = mul_prod;
          ex_next    = {1'b0, ex[DW-1:1]};
          state_next = ST_PLOOP;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // a new prime restarts key derivation
    if (wr_en && (wr_index == REG_PRIME_P || wr_index == REG_PRIME_Q)) begin
      state_next = ST_KINIT;
    end
  end

`include "small_rsa_crypt_unit_assert.svh"

  `SRSA_ASSERT_NOW(a_ok_key, done && status == STAT_OK, key_modulus != '0 && pub_exponent != '0)
  `SRSA_ASSERT_NOW(a_done_idle, done, !busy)
  `SRSA_ASSERT_NEXT(a_start_busy, start && !busy && !wr_en, busy || done)
  `SRSA_ASSERT_NOW(a_bad_zero, done && status == STAT_BAD_PRIMES, key_modulus == '0)

endmodule
